[rtl/mtwq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtwq_pkg
// Shared types and codes for the mutex table with wait queues.
// ----------------------------------------------------------------------------
package mtwq_pkg;

    localparam int NUM_MUTEXES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int FUNC_W   = 2;
    localparam int MID_W    = 4;
    localparam int PID_W    = 8;
    localparam int STATUS_W = 3;

    // request codes
    localparam logic [FUNC_W-1:0] FN_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLOSE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOCK   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_UNLOCK = 2'd3;

    // result codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HANDOVER = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MID_W-1:0]  mutex_id;
        logic [PID_W-1:0]  requester_pid;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MID_W-1:0]    slot_id;
        logic [PID_W-1:0]    woken_pid;
        logic                woken_valid;
    } t_rsp;

endpackage
`default_nettype wire

[rtl/mtwq_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtwq_req_if / mtwq_rsp_if
// Valid/ready channels for requests and results of the mutex table.
// ----------------------------------------------------------------------------
interface mtwq_req_if;
    logic            valid;
    logic            ready;
    mtwq_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mtwq_rsp_if;
    logic            valid;
    logic            ready;
    mtwq_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/mutex_table_with_wait_queues.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mutex_table_with_wait_queues
// Lock manager: a table of mutex slots, each with a FIFO ring of waiting pids.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                   | accepted when
//  ---------+-----+-------------------------------------------+-----------------
//  i_req    | in  | func, mutex_id, requester_pid             | valid && ready
//  o_rsp    | out | status, slot_id, woken_pid, woken_valid   | valid && ready
//
// Steps: an item is accepted with its slot table read (S_IDLE), then decided
//   and written back (S_EXEC); an unlock that hands over also reads the waiter
//   memory at the queue head, then writes back in S_POP. One item is in flight.
// The slot table memory is read in the accept cycle and written in the last
//   cycle, so the next item always reads settled data.
// Reset: control clears at once; each slot has a valid bit that makes an
//   unwritten table entry read as zero. No clearing pass.
// Stalls: i_req is taken whenever no item is in flight, even while a result
//   waits in the output register; the final cycle waits for that register.
//
module mutex_table_with_wait_queues #(
    parameter int NUM_MUTEXES = mtwq_pkg::NUM_MUTEXES_DEF,
    parameter int QUEUE_DEPTH = mtwq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mtwq_req_if.sink        i_req,
    mtwq_rsp_if.source      o_rsp
);
    import mtwq_pkg::*;

    localparam int IW   = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int WN   = NUM_MUTEXES * QUEUE_DEPTH;
    localparam int WAW  = (WN > 1) ? $clog2(WN) : 1;

    // per-slot record kept in the table memory (in-use mark lives in flops
    // so the free-slot search can see all slots at once)
    typedef struct packed {
        logic             lock;
        logic [PID_W-1:0] owner;
        logic [PID_W-1:0] creator;
        logic [QW-1:0]    head;
        logic [QW-1:0]    tail;
        logic [CW-1:0]    count;
    } t_entry;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_POP} t_state;

    function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] pos);
        return (pos == QW'(QUEUE_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    function automatic logic [WAW-1:0] wait_addr(input logic [IW-1:0] idx,
                                                 input logic [QW-1:0] pos);
        logic [14:0] t;
        t = 15'(idx) * 15'(QUEUE_DEPTH) + 15'(pos);
        return t[WAW-1:0];
    endfunction

    // memories
    t_entry           m_tab  [NUM_MUTEXES];
    logic [PID_W-1:0] m_wait [WN];

    // registers
    t_state                r_state;
    logic [FUNC_W-1:0]     r_func;
    logic [IW-1:0]         r_idx;
    logic [PID_W-1:0]      r_pid;
    logic                  r_inrange;
    logic                  r_any_free;
    t_entry                r_rd;
    logic                  r_rd_vld;
    logic [PID_W-1:0]      r_wrd;
    logic                  r_out_valid;
    t_rsp                  r_out;
    logic [NUM_MUTEXES-1:0] r_used;
    logic [NUM_MUTEXES-1:0] r_ent_vld;

    // next values
    t_state                n_state;
    logic                  n_out_valid;
    t_rsp                  n_out;
    logic [NUM_MUTEXES-1:0] n_used;
    logic [NUM_MUTEXES-1:0] n_ent_vld;

    // combinational
    logic                  accept;
    logic                  out_free;
    logic [8:0]            id_ext;
    logic [IW-1:0]         id_idx;
    logic [NUM_MUTEXES-1:0] free_oh;
    logic [IW-1:0]         free_idx;
    logic                  any_free;
    logic [IW-1:0]         sel_idx;
    t_entry                ent;
    logic [8:0]            slot_ext;

    logic                  tab_we;
    t_entry                tab_wd;
    logic                  wq_we;
    logic [WAW-1:0]        wq_waddr;
    logic                  wq_re;
    logic [WAW-1:0]        wq_raddr;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign id_ext = {5'b0, i_req.data.mutex_id};
    assign id_idx = id_ext[IW-1:0];

    // lowest free slot: isolate the lowest zero of the in-use vector
    assign free_oh  = ~r_used & (r_used + 1'b1);
    assign any_free = |(~r_used);
    always_comb begin
        free_idx = '0;
        for (int i = 0; i < NUM_MUTEXES; i++) begin
            if (free_oh[i]) begin
                free_idx = free_idx | IW'(i);
            end
        end
    end

    assign sel_idx  = (i_req.data.func == FN_CREATE) ? free_idx : id_idx;
    assign ent      = r_rd_vld ? r_rd : '0;
    assign slot_ext = 9'(r_idx);

    // decide and write back
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        n_used      = r_used;
        n_ent_vld   = r_ent_vld;
        tab_we      = 1'b0;
        tab_wd      = ent;
        wq_we       = 1'b0;
        wq_waddr    = wait_addr(r_idx, ent.tail);
        wq_re       = 1'b0;
        wq_raddr    = wait_addr(r_idx, ent.head);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_IGNORED, slot_id: '0,
                                    woken_pid: '0, woken_valid: 1'b0};
                    case (r_func)
                        FN_CREATE: begin
                            if (r_any_free) begin
                                n_used[r_idx]    = 1'b1;
                                n_ent_vld[r_idx] = 1'b1;
                                tab_we           = 1'b1;
                                tab_wd           = '0;
                                tab_wd.creator   = r_pid;
                                n_out.status     = ST_DONE;
                                n_out.slot_id    = slot_ext[3:0];
                            end else begin
                                n_out.status = ST_NOSLOT;
                            end
                        end
                        FN_CLOSE: begin
                            if (r_inrange && r_used[r_idx] && ent.creator == r_pid) begin
                                n_used[r_idx] = 1'b0;
                                n_out.status  = ST_DONE;
                            end
                        end
                        FN_LOCK: begin
                            if (r_inrange && r_used[r_idx]) begin
                                if (!ent.lock) begin
                                    tab_we       = 1'b1;
                                    tab_wd.lock  = 1'b1;
                                    tab_wd.owner = r_pid;
                                    n_out.status = ST_DONE;
                                end else if (ent.count < CW'(QUEUE_DEPTH)) begin
                                    wq_we        = 1'b1;
                                    tab_we       = 1'b1;
                                    tab_wd.tail  = ring_next(ent.tail);
                                    tab_wd.count = ent.count + 1'b1;
                                    n_out.status = ST_QUEUED;
                                end else begin
                                    n_out.status = ST_FULL;
                                end
                                n_ent_vld[r_idx] = r_ent_vld[r_idx] | tab_we;
                            end
                        end
                        FN_UNLOCK: begin
                            if (r_inrange) begin
                                if (ent.count != '0 || !r_used[r_idx]) begin
                                    // handover: fetch the oldest waiter first
                                    if (ent.owner == r_pid && ent.count != '0) begin
                                        wq_re       = 1'b1;
                                        n_state     = S_POP;
                                        n_out_valid = r_out_valid && !o_rsp.ready;
                                        n_out       = r_out;
                                    end
                                end else begin
                                    tab_we           = 1'b1;
                                    tab_wd.lock      = 1'b0;
                                    n_ent_vld[r_idx] = 1'b1;
                                    n_out.status     = ST_DONE;
                                end
                            end
                        end
                        default: begin
                            n_out.status = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_state          = S_IDLE;
                    tab_we           = 1'b1;
                    tab_wd.owner     = r_wrd;
                    tab_wd.head      = ring_next(ent.head);
                    tab_wd.count     = ent.count - 1'b1;
                    n_ent_vld[r_idx] = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out            = '{status: ST_HANDOVER, slot_id: '0,
                                         woken_pid: r_wrd, woken_valid: 1'b1};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot table memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= m_tab[sel_idx];
        end
        if (tab_we) begin
            m_tab[r_idx] <= tab_wd;
        end
    end

    // waiter ring memory
    always_ff @(posedge i_clk) begin
        if (wq_re) begin
            r_wrd <= m_wait[wq_raddr];
        end
        if (wq_we) begin
            m_wait[wq_waddr] <= r_pid;
        end
    end

    // control state, request capture and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_ent_vld   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_used      <= n_used;
            r_ent_vld   <= n_ent_vld;
        end
        r_out <= n_out;
        if (accept) begin
            r_func     <= i_req.data.func;
            r_idx      <= sel_idx;
            r_pid      <= i_req.data.requester_pid;
            r_inrange  <= (id_ext < 9'(NUM_MUTEXES));
            r_any_free <= any_free;
            r_rd_vld   <= r_ent_vld[sel_idx];
        end
    end

endmodule
`default_nettype wire
